// ----- hdl/ata_transfer_address_translate_macros.svh -----
// Assertion helpers for the address translation block.
// Both expect clk and arst_n to be visible in the scope where they are used.
`ifndef ATA_TRANSFER_ADDRESS_TRANSLATE_MACROS_SVH
`define ATA_TRANSFER_ADDRESS_TRANSLATE_MACROS_SVH

// Same-cycle implication.
`define ATA_CHECK(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ata assertion failed");

// Next-cycle implication.
`define ATA_CHECK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ata assertion failed");

`endif

// ----- hdl/ata_pkg.sv -----
package ata_pkg;

	localparam int MAX_XFER_BYTES = 16 * 1024;
	localparam int SB_W = 13;
	localparam int MIN_SB = 512;
	localparam int MAX_SB = 4096;
	localparam int XFER_W = $clog2(MAX_XFER_BYTES + MAX_SB);
	localparam int DIV_STEPS = 32;
	localparam int MOD_STEPS = 12;

	localparam logic [7:0] CMD_READ = 8'h20;
	localparam logic [7:0] CMD_WRITE = 8'h30;
	localparam logic [7:0] DH_BASE = 8'hA0;
	localparam logic [7:0] DH_SLAVE = 8'h10;
	localparam logic [7:0] DH_LBA = 8'h40;

	typedef enum logic [2:0] {
		REG_SECTOR_BYTES = 3'd0,
		REG_LBA_MODE = 3'd1,
		REG_SPT = 3'd2,
		REG_HEAD_COUNT = 3'd3,
		REG_PART_START = 3'd4,
		REG_PART_END = 3'd5,
		REG_SLAVE = 3'd6
	} reg_index_t;

	// One lane of a restoring divider: partial remainder and the dividend
	// that shifts out at the top while quotient bits shift in at the bottom.
	typedef struct packed {
		logic [SB_W-1:0] rem;
		logic [31:0] dvd;
	} lane_t;

	typedef struct packed {
		logic valid;
		logic opcode;
		logic past;
		logic [5:0] count;
		logic [31:0] lsec;
		logic [15:0] cyl;
	} side_t;

endpackage

// ----- hdl/ata_if.sv -----
interface ata_req_if;
	logic valid;
	logic ready;
	logic opcode;
	logic [31:0] byte_offset;
	logic [30:0] byte_length;

	modport source(output valid, opcode, byte_offset, byte_length, input ready);
	modport sink(input valid, opcode, byte_offset, byte_length, output ready);
endinterface

interface ata_rsp_if;
	logic valid;
	logic ready;
	logic status;
	logic [7:0] command_byte;
	logic [5:0] sector_count;
	logic [7:0] sector_number;
	logic [15:0] cylinder;
	logic [7:0] drive_head_byte;
	logic [14:0] byte_count;

	modport source(output valid, status, command_byte, sector_count, sector_number,
		cylinder, drive_head_byte, byte_count, input ready);
	modport sink(input valid, status, command_byte, sector_count, sector_number,
		cylinder, drive_head_byte, byte_count, output ready);
endinterface

// ----- hdl/ata_div_cell.sv -----
module ata_div_cell import ata_pkg::*; (
	input logic clk,
	input logic en,
	input lane_t lane_i,
	input logic [SB_W-1:0] divisor,
	output lane_t lane_o
);

	logic [SB_W:0] trial;
	logic fits;
	logic [SB_W:0] diff;

	always_comb begin
		trial = {lane_i.rem, lane_i.dvd[31]};
		fits = trial >= {1'b0, divisor};
		diff = trial - {1'b0, divisor};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_o.rem <= fits ? diff[SB_W-1:0] : trial[SB_W-1:0];
			lane_o.dvd <= {lane_i.dvd[30:0], fits};
		end
	end

endmodule

// ----- hdl/ata_transfer_address_translate.sv -----
// ATA transfer address translation. Each request transfer (opcode, byte
// offset, byte length) yields one response transfer holding the task-file
// values. The block accepts one request per cycle while the response is not
// stalled; each request passes through two rows of 32 restoring division
// cells (offset by sector size, then logical sector by sectors-per-cylinder),
// one add/clamp stage, a row of 12 cells for head and sector, and the output
// register. When the response is held by a stalled sink, the whole cell chain
// holds with it and req.ready drops. Configuration writes must only be made
// while no request is in flight.
module ata_transfer_address_translate import ata_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data,
	ata_req_if.sink req,
	ata_rsp_if.source rsp
);

	// Configuration registers.
	logic [SB_W-1:0] sector_bytes_q;
	logic lba_mode_q;
	logic [7:0] spt_q;
	logic [4:0] head_count_q;
	logic [31:0] part_start_q;
	logic [31:0] part_end_q;
	logic slave_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_bytes_q <= SB_W'(MIN_SB);
			lba_mode_q <= 1'b0;
			spt_q <= 8'd63;
			head_count_q <= 5'd16;
			part_start_q <= '0;
			part_end_q <= '0;
			slave_q <= 1'b0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_SECTOR_BYTES: sector_bytes_q <= cfg_data[SB_W-1:0];
				REG_LBA_MODE: lba_mode_q <= cfg_data[0];
				REG_SPT: spt_q <= cfg_data[7:0];
				REG_HEAD_COUNT: head_count_q <= cfg_data[4:0];
				REG_PART_START: part_start_q <= cfg_data;
				REG_PART_END: part_end_q <= cfg_data;
				REG_SLAVE: slave_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Out-of-range geometry and sector size are pulled into their legal ranges.
	logic [SB_W-1:0] bps;
	logic [7:0] spt;
	logic [4:0] heads;
	logic [12:0] spc;

	always_comb begin
		if (sector_bytes_q < SB_W'(MIN_SB)) bps = SB_W'(MIN_SB);
		else if (sector_bytes_q > SB_W'(MAX_SB)) bps = SB_W'(MAX_SB);
		else bps = sector_bytes_q;
		spt = (spt_q == 8'd0) ? 8'd1 : spt_q;
		if (head_count_q == 5'd0) heads = 5'd1;
		else if (head_count_q > 5'd16) heads = 5'd16;
		else heads = head_count_q;
		spc = 13'(spt * heads);
	end

	// The whole chain advances together unless a response is stuck.
	logic out_valid_q;
	logic en;
	assign en = !out_valid_q || rsp.ready;
	assign req.ready = en;

	// Length capped at the largest transfer, biased for round-up division.
	logic [XFER_W-1:0] len_num;
	always_comb begin
		if (req.byte_length > 31'(MAX_XFER_BYTES))
			len_num = XFER_W'(MAX_XFER_BYTES) + XFER_W'(bps) - XFER_W'(1);
		else
			len_num = XFER_W'(req.byte_length) + XFER_W'(bps) - XFER_W'(1);
	end

	// Row A: sector offset and sector count, both divided by the sector size.
	lane_t lane_a [DIV_STEPS+1];
	lane_t lane_b [DIV_STEPS+1];
	side_t side_a_s [DIV_STEPS+1];

	assign lane_a[0] = '{rem: '0, dvd: req.byte_offset};
	assign lane_b[0] = '{rem: '0, dvd: 32'(len_num)};
	assign side_a_s[0] = '{valid: req.valid, opcode: req.opcode, past: 1'b0,
		count: '0, lsec: '0, cyl: '0};

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_row_a
		ata_div_cell u_off (.clk, .en, .lane_i(lane_a[k]), .divisor(bps),
			.lane_o(lane_a[k+1]));
		ata_div_cell u_len (.clk, .en, .lane_i(lane_b[k]), .divisor(bps),
			.lane_o(lane_b[k+1]));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) side_a_s[k+1] <= '0;
			else if (en) side_a_s[k+1] <= side_a_s[k];
		end
	end

	// Add the partition start, flag a start past the end, and clamp the count
	// so the transfer stops at the partition end.
	logic [31:0] lsec;
	logic [31:0] room;
	logic [31:0] cnt_raw;
	side_t mid_s1;

	always_comb begin
		lsec = lane_a[DIV_STEPS].dvd + part_start_q;
		room = part_end_q - lsec;
		cnt_raw = {26'd0, lane_b[DIV_STEPS].dvd[5:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_s1 <= '0;
		end else if (en) begin
			mid_s1.valid <= side_a_s[DIV_STEPS].valid;
			mid_s1.opcode <= side_a_s[DIV_STEPS].opcode;
			mid_s1.past <= lsec >= part_end_q;
			mid_s1.count <= (cnt_raw > room) ? room[5:0] : cnt_raw[5:0];
			mid_s1.lsec <= lsec;
			mid_s1.cyl <= '0;
		end
	end

	// Row C: logical sector by sectors per cylinder gives the cylinder; the
	// remainder is the sector within the cylinder.
	lane_t lane_c [DIV_STEPS+1];
	side_t side_c_s [DIV_STEPS+1];

	assign lane_c[0] = '{rem: '0, dvd: mid_s1.lsec};
	assign side_c_s[0] = mid_s1;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_row_c
		ata_div_cell u_cyl (.clk, .en, .lane_i(lane_c[k]), .divisor(spc),
			.lane_o(lane_c[k+1]));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) side_c_s[k+1] <= '0;
			else if (en) side_c_s[k+1] <= side_c_s[k];
		end
	end

	// Row E: the sector within the cylinder divided by sectors per track gives
	// the head as quotient and the zero-based sector as remainder.
	lane_t lane_e [MOD_STEPS+1];
	side_t side_e_s [MOD_STEPS+1];

	always_comb begin
		lane_e[0] = '{rem: '0, dvd: {lane_c[DIV_STEPS].rem[MOD_STEPS-1:0],
			(32 - MOD_STEPS)'(0)}};
		side_e_s[0] = side_c_s[DIV_STEPS];
		side_e_s[0].cyl = lane_c[DIV_STEPS].dvd[15:0];
	end

	for (genvar k = 0; k < MOD_STEPS; k++) begin : g_row_e
		ata_div_cell u_hs (.clk, .en, .lane_i(lane_e[k]), .divisor({5'd0, spt}),
			.lane_o(lane_e[k+1]));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) side_e_s[k+1] <= '0;
			else if (en) side_e_s[k+1] <= side_e_s[k];
		end
	end

	// Response assembly.
	side_t fin;
	logic [7:0] secnum;
	logic [15:0] cyl;
	logic [3:0] head;
	logic [18:0] bytes;

	always_comb begin
		fin = side_e_s[MOD_STEPS];
		if (lba_mode_q) begin
			secnum = fin.lsec[7:0];
			cyl = fin.lsec[23:8];
			head = fin.lsec[27:24];
		end else begin
			secnum = lane_e[MOD_STEPS].rem[7:0] + 8'd1;
			cyl = fin.cyl;
			head = lane_e[MOD_STEPS].dvd[3:0];
		end
		bytes = 19'(fin.count * bps);
	end

	logic status_q;
	logic [7:0] cmd_q;
	logic [5:0] count_q;
	logic [7:0] secnum_q;
	logic [15:0] cyl_q;
	logic [7:0] dh_q;
	logic [14:0] bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= fin.valid;
	end

	// A start past the end reports only the status; every other field is zero.
	always_ff @(posedge clk) begin
		if (en) begin
			status_q <= fin.past;
			if (fin.past) begin
				cmd_q <= '0;
				count_q <= '0;
				secnum_q <= '0;
				cyl_q <= '0;
				dh_q <= '0;
				bytes_q <= '0;
			end else begin
				cmd_q <= fin.opcode ? CMD_WRITE : CMD_READ;
				count_q <= fin.count;
				secnum_q <= secnum;
				cyl_q <= cyl;
				dh_q <= DH_BASE | (slave_q ? DH_SLAVE : 8'h00) |
					(lba_mode_q ? DH_LBA : 8'h00) | {4'h0, head};
				bytes_q <= bytes[14:0];
			end
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = status_q;
	assign rsp.command_byte = cmd_q;
	assign rsp.sector_count = count_q;
	assign rsp.sector_number = secnum_q;
	assign rsp.cylinder = cyl_q;
	assign rsp.drive_head_byte = dh_q;
	assign rsp.byte_count = bytes_q;

endmodule

// ----- hdl/ata_chk.sv -----
`include "ata_transfer_address_translate_macros.svh"

module ata_chk import ata_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic req_ready,
	input logic status,
	input logic [7:0] command_byte,
	input logic [5:0] sector_count,
	input logic [7:0] drive_head_byte,
	input logic [14:0] byte_count
);

	// A stalled response must hold the request side back as well.
	`ATA_CHECK(a_stall_blocks, rsp_valid && !rsp_ready, !req_ready)
	// A start past the end carries no command and no count.
	`ATA_CHECK(a_past_zero, rsp_valid && status,
		command_byte == 8'h00 && sector_count == 6'd0 && byte_count == 15'd0)
	// A good response always names a read or write and sets the fixed bits.
	`ATA_CHECK(a_ok_cmd, rsp_valid && !status,
		(command_byte == CMD_READ || command_byte == CMD_WRITE) &&
		((drive_head_byte & DH_BASE) == DH_BASE))
	// A held response keeps its payload.
	`ATA_CHECK_NEXT(a_hold, rsp_valid && !rsp_ready,
		rsp_valid && $stable(command_byte) && $stable(sector_count) && $stable(status))

endmodule

bind ata_transfer_address_translate ata_chk u_ata_chk (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.req_ready(req.ready),
	.status(rsp.status),
	.command_byte(rsp.command_byte),
	.sector_count(rsp.sector_count),
	.drive_head_byte(rsp.drive_head_byte),
	.byte_count(rsp.byte_count)
);
